### sv/ray_ellipsoid_intersect_assert.svh
// Assertion macros for the ray/ellipsoid intersection block.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef RAY_ELLIPSOID_INTERSECT_ASSERT_SVH
`define RAY_ELLIPSOID_INTERSECT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define REI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define REI_ASSERT_DELAY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error(msg);
`else
`define REI_ASSERT_IMP(lbl, ante, cons, msg)
`define REI_ASSERT_DELAY(lbl, ante, n, cons, msg)
`endif
`endif

### sv/rei_pkg.sv
// Shared types, constants and helper functions for the ray/ellipsoid block.
// No dependencies.
package rei_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int CW_EFF      = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);
    localparam int CW_SHIFT    = 32 - CW_EFF;

    localparam logic signed [47:0] CW_MAX = (48'sd1 <<< (CW_EFF - 1)) - 48'sd1;
    localparam logic signed [47:0] CW_MIN = -CW_MAX - 48'sd1;

    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROW0_LO = 3'd0,
        REG_ROW0_HI = 3'd1,
        REG_ROW1_LO = 3'd2,
        REG_ROW1_HI = 3'd3,
        REG_ROW2_LO = 3'd4,
        REG_ROW2_HI = 3'd5,
        REG_EPSILON = 3'd6
    } reg_idx_t;

    localparam logic [63:0] RST_ROW0_LO = 64'd281474976710656;
    localparam logic [63:0] RST_ROW0_HI = 64'd0;
    localparam logic [63:0] RST_ROW1_LO = 64'd65536;
    localparam logic [63:0] RST_ROW1_HI = 64'd0;
    localparam logic [63:0] RST_ROW2_LO = 64'd0;
    localparam logic [63:0] RST_ROW2_HI = 64'd281474976710656;
    localparam logic [15:0] RST_EPSILON = 16'd1;

    localparam int SQ_STEPS  = 64;
    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT   = DIV_STEPS + 3;
    localparam int LAT       = 7 + SQ_STEPS + 1 + DIV_LAT + 1;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] best_distance;
        logic               prior_hit;
    } ray_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] new_distance;
    } res_t;

    typedef struct packed {
        logic               prior;
        logic signed [31:0] best;
    } carry_t;

    typedef struct packed {
        logic [66:0] rem;
        logic [63:0] root;
    } sq_core_t;

    typedef struct packed {
        logic               prior;
        logic signed [31:0] best;
        logic               a_ok;
        logic               small_disc;
        logic               pri_ok;
        logic [62:0]        den;
        logic signed [64:0] nb;
        logic [127:0]       x;
        sq_core_t           core;
    } sq_t;

    typedef struct packed {
        logic               prior;
        logic signed [31:0] best;
        logic               a_ok;
        logic               small_disc;
        logic               pri_ok;
    } side_t;

    function automatic logic signed [63:0] sat64(input logic signed [66:0] acc);
        logic signed [63:0] r;
        if (acc[66:63] == 4'b0000 || acc[66:63] == 4'b1111) begin
            r = acc[63:0];
        end else if (acc[66]) begin
            r = {1'b1, 63'd0};
        end else begin
            r = {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [31:0] coord_fin(input logic signed [66:0] acc);
        logic signed [63:0] s;
        logic signed [47:0] sh;
        logic signed [47:0] c;
        s  = sat64(acc);
        sh = s[63:16];
        if (sh > CW_MAX) begin
            c = CW_MAX;
        end else if (sh < CW_MIN) begin
            c = CW_MIN;
        end else begin
            c = sh;
        end
        return c[31:0];
    endfunction

    function automatic sq_core_t sqrt_step(input sq_core_t cur, input logic [1:0] bits);
        logic [66:0] r;
        logic [66:0] tr;
        sq_core_t    nx;
        r  = {cur.rem[64:0], bits};
        tr = {1'b0, cur.root, 2'b01};
        if (r >= tr) begin
            nx.rem  = r - tr;
            nx.root = {cur.root[62:0], 1'b1};
        end else begin
            nx.rem  = r;
            nx.root = {cur.root[62:0], 1'b0};
        end
        return nx;
    endfunction

endpackage

### sv/rei_div.sv
// Pipelined signed fixed-point divider: (num * 2^16) / den, saturated to 32 bits.
// Depends on rei_pkg for the step count.
module rei_div (
    input  logic               clk,
    input  logic signed [66:0] num,
    input  logic [62:0]        den,
    output logic signed [31:0] lam
);

    typedef struct packed {
        logic        neg;
        logic        big;
        logic [62:0] den;
        logic [62:0] rem;
        logic [31:0] lo;
        logic [31:0] q;
    } dv_t;

    logic               a_neg_reg;
    logic [65:0]        a_mag_reg;
    logic [62:0]        a_den_reg;
    logic [65:0]        mag_next;
    logic [62:0]        hi_w;
    dv_t                dv_reg  [rei_pkg::DIV_STEPS+1];
    dv_t                dv_next [rei_pkg::DIV_STEPS+1];
    logic signed [31:0] lam_reg;
    logic signed [31:0] lam_next;

    assign mag_next = num[66] ? 66'(~num + 67'd1) : num[65:0];

    always_ff @(posedge clk)
    begin
        a_neg_reg <= num[66];
        a_mag_reg <= mag_next;
        a_den_reg <= den;
    end

    always_comb
    begin
        hi_w           = {13'd0, a_mag_reg[65:16]};
        dv_next[0].neg = a_neg_reg;
        dv_next[0].big = (hi_w >= a_den_reg);
        dv_next[0].den = a_den_reg;
        dv_next[0].rem = (hi_w >= a_den_reg) ? 63'd0 : hi_w;
        dv_next[0].lo  = {a_mag_reg[15:0], 16'h0000};
        dv_next[0].q   = 32'd0;
    end

    always_ff @(posedge clk)
    begin
        dv_reg[0] <= dv_next[0];
    end

    for (genvar k = 0; k < rei_pkg::DIV_STEPS; k++) begin : g_step
        logic [63:0] t_w;
        always_comb
        begin
            t_w              = {dv_reg[k].rem, dv_reg[k].lo[31]};
            dv_next[k+1]     = dv_reg[k];
            dv_next[k+1].lo  = {dv_reg[k].lo[30:0], 1'b0};
            if (t_w >= {1'b0, dv_reg[k].den}) begin
                dv_next[k+1].rem = 63'(t_w - {1'b0, dv_reg[k].den});
                dv_next[k+1].q   = {dv_reg[k].q[30:0], 1'b1};
            end else begin
                dv_next[k+1].rem = t_w[62:0];
                dv_next[k+1].q   = {dv_reg[k].q[30:0], 1'b0};
            end
        end
        always_ff @(posedge clk)
        begin
            dv_reg[k+1] <= dv_next[k+1];
        end
    end

    always_comb
    begin
        if (dv_reg[rei_pkg::DIV_STEPS].neg) begin
            if (dv_reg[rei_pkg::DIV_STEPS].big || dv_reg[rei_pkg::DIV_STEPS].q > 32'h8000_0000)
            begin
                lam_next = {1'b1, 31'd0};
            end else begin
                lam_next = -$signed(dv_reg[rei_pkg::DIV_STEPS].q);
            end
        end else begin
            if (dv_reg[rei_pkg::DIV_STEPS].big || dv_reg[rei_pkg::DIV_STEPS].q > 32'h7FFF_FFFF)
            begin
                lam_next = {1'b0, {31{1'b1}}};
            end else begin
                lam_next = $signed(dv_reg[rei_pkg::DIV_STEPS].q);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lam_reg <= lam_next;
    end

    assign lam = lam_reg;

endmodule

### sv/ray_ellipsoid_intersect.sv
// Ray/ellipsoid intersection, Q16.16 in and out, fully pipelined.
// Every accepted item produces a done strobe; one item per cycle.
// Depth is set by the 64-step square root and the 32-step quotient pipelines.
// busy is never raised; done pulses for one cycle per item.
// Reset clears all valid bits and loads identity matrix, zero offset, epsilon 1.
// Depends on rei_pkg, rei_div and ray_ellipsoid_intersect_assert.svh.
`include "ray_ellipsoid_intersect_assert.svh"
module ray_ellipsoid_intersect (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  rei_pkg::ray_t                    ray,
    input  logic                             cfg_wen,
    input  logic [rei_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                      cfg_data,
    output logic                             done,
    output rei_pkg::res_t                    result
);

    logic [63:0]        row_reg [6];
    logic [15:0]        eps_reg;
    logic signed [31:0] m_w     [3][3];
    logic signed [31:0] t_w     [3];
    logic signed [31:0] ow_w    [3];
    logic signed [31:0] dw_w    [3];

    logic               p1_vld_reg;
    rei_pkg::carry_t    p1_reg;
    logic signed [63:0] om_reg [3][3];
    logic signed [63:0] dm_reg [3][3];

    logic               p2_vld_reg;
    rei_pkg::carry_t    p2_reg;
    logic signed [31:0] o_reg [3];
    logic signed [31:0] d_reg [3];
    logic signed [31:0] o_next [3];
    logic signed [31:0] d_next [3];

    logic               p3_vld_reg;
    rei_pkg::carry_t    p3_reg;
    logic signed [63:0] dd_reg [3];
    logic signed [63:0] dox_reg [3];
    logic signed [63:0] oo_reg [3];

    logic               p4_vld_reg;
    rei_pkg::carry_t    p4_reg;
    logic signed [63:0] a_reg, b_reg, c_reg;
    logic signed [63:0] a_next, b_next, c_next;

    logic               p5_vld_reg;
    rei_pkg::carry_t    p5_reg;
    logic signed [63:0] a5_reg, b5_reg;
    logic signed [63:0] bhh_reg, ahh_reg;
    logic signed [64:0] bhl_reg, ahl_reg, alh_reg;
    logic [63:0]        bll_reg, all_reg;

    logic               p6_vld_reg;
    rei_pkg::carry_t    p6_reg;
    logic signed [63:0] a6_reg, b6_reg;
    logic [127:0]       bb_reg, ac_reg;
    logic [127:0]       bb_next, ac_next;

    logic               sq_vld_reg [rei_pkg::SQ_STEPS+1];
    rei_pkg::sq_t       sq_reg     [rei_pkg::SQ_STEPS+1];
    rei_pkg::sq_t       sq_next    [rei_pkg::SQ_STEPS+1];
    logic [127:0]       disc_w;
    logic [64:0]        bsum_w;

    logic signed [66:0] num0_reg, num1_reg;
    logic signed [66:0] num0_next, num1_next;
    logic [62:0]        den_reg;
    logic               side_vld_reg [rei_pkg::DIV_LAT+1];
    rei_pkg::side_t     side_reg     [rei_pkg::DIV_LAT+1];
    rei_pkg::side_t     side_next;
    logic signed [31:0] lam0_w, lam1_w;

    logic               done_reg;
    rei_pkg::res_t      result_reg;
    rei_pkg::res_t      result_next;
    logic signed [31:0] eps_s;
    rei_pkg::side_t     fin_w;

    assign busy = 1'b0;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_reg[0] <= rei_pkg::RST_ROW0_LO;
            row_reg[1] <= rei_pkg::RST_ROW0_HI;
            row_reg[2] <= rei_pkg::RST_ROW1_LO;
            row_reg[3] <= rei_pkg::RST_ROW1_HI;
            row_reg[4] <= rei_pkg::RST_ROW2_LO;
            row_reg[5] <= rei_pkg::RST_ROW2_HI;
            eps_reg    <= rei_pkg::RST_EPSILON;
        end else if (cfg_wen) begin
            case (rei_pkg::reg_idx_t'(cfg_index))
                rei_pkg::REG_ROW0_LO: row_reg[0] <= cfg_data;
                rei_pkg::REG_ROW0_HI: row_reg[1] <= cfg_data;
                rei_pkg::REG_ROW1_LO: row_reg[2] <= cfg_data;
                rei_pkg::REG_ROW1_HI: row_reg[3] <= cfg_data;
                rei_pkg::REG_ROW2_LO: row_reg[4] <= cfg_data;
                rei_pkg::REG_ROW2_HI: row_reg[5] <= cfg_data;
                rei_pkg::REG_EPSILON: eps_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            m_w[i][0] = row_reg[2*i][63:32];
            m_w[i][1] = row_reg[2*i][31:0];
            m_w[i][2] = row_reg[2*i+1][63:32];
            t_w[i]    = row_reg[2*i+1][31:0];
        end
        ow_w[0] = (ray.origin_x <<< rei_pkg::CW_SHIFT) >>> rei_pkg::CW_SHIFT;
        ow_w[1] = (ray.origin_y <<< rei_pkg::CW_SHIFT) >>> rei_pkg::CW_SHIFT;
        ow_w[2] = (ray.origin_z <<< rei_pkg::CW_SHIFT) >>> rei_pkg::CW_SHIFT;
        dw_w[0] = (ray.dir_x <<< rei_pkg::CW_SHIFT) >>> rei_pkg::CW_SHIFT;
        dw_w[1] = (ray.dir_y <<< rei_pkg::CW_SHIFT) >>> rei_pkg::CW_SHIFT;
        dw_w[2] = (ray.dir_z <<< rei_pkg::CW_SHIFT) >>> rei_pkg::CW_SHIFT;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            p3_vld_reg     <= 1'b0;
            p4_vld_reg     <= 1'b0;
            p5_vld_reg     <= 1'b0;
            p6_vld_reg     <= 1'b0;
            sq_vld_reg[0]  <= 1'b0;
            side_vld_reg[0] <= 1'b0;
            done_reg       <= 1'b0;
        end else begin
            p1_vld_reg     <= start && !busy;
            p2_vld_reg     <= p1_vld_reg;
            p3_vld_reg     <= p2_vld_reg;
            p4_vld_reg     <= p3_vld_reg;
            p5_vld_reg     <= p4_vld_reg;
            p6_vld_reg     <= p5_vld_reg;
            sq_vld_reg[0]  <= p6_vld_reg;
            side_vld_reg[0] <= sq_vld_reg[rei_pkg::SQ_STEPS];
            done_reg       <= side_vld_reg[rei_pkg::DIV_LAT];
        end
    end

    // stage 1: matrix products
    always_ff @(posedge clk)
    begin
        p1_reg.prior <= ray.prior_hit;
        p1_reg.best  <= ray.best_distance;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                om_reg[i][j] <= m_w[i][j] * ow_w[j];
                dm_reg[i][j] <= m_w[i][j] * dw_w[j];
            end
        end
    end

    // stage 2: local-frame coordinates
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            o_next[i] = rei_pkg::coord_fin(67'(om_reg[i][0]) + 67'(om_reg[i][1])
                        + 67'(om_reg[i][2]) + (67'(t_w[i]) <<< 16));
            d_next[i] = rei_pkg::coord_fin(67'(dm_reg[i][0]) + 67'(dm_reg[i][1])
                        + 67'(dm_reg[i][2]));
        end
    end

    always_ff @(posedge clk)
    begin
        p2_reg <= p1_reg;
        for (int i = 0; i < 3; i++) begin
            o_reg[i] <= o_next[i];
            d_reg[i] <= d_next[i];
        end
    end

    // stage 3: dot-product terms
    always_ff @(posedge clk)
    begin
        p3_reg <= p2_reg;
        for (int i = 0; i < 3; i++) begin
            dd_reg[i]  <= d_reg[i] * d_reg[i];
            dox_reg[i] <= d_reg[i] * o_reg[i];
            oo_reg[i]  <= o_reg[i] * o_reg[i];
        end
    end

    // stage 4: quadratic coefficients
    always_comb
    begin
        a_next = rei_pkg::sat64(67'(dd_reg[0]) + 67'(dd_reg[1]) + 67'(dd_reg[2]));
        b_next = rei_pkg::sat64(67'(dox_reg[0]) + 67'(dox_reg[1]) + 67'(dox_reg[2]));
        c_next = rei_pkg::sat64(67'(oo_reg[0]) + 67'(oo_reg[1]) + 67'(oo_reg[2])
                 - (67'sd1 <<< 32));
    end

    always_ff @(posedge clk)
    begin
        p4_reg <= p3_reg;
        a_reg  <= a_next;
        b_reg  <= b_next;
        c_reg  <= c_next;
    end

    // stage 5: partial products of b*b and a*c
    always_ff @(posedge clk)
    begin
        p5_reg  <= p4_reg;
        a5_reg  <= a_reg;
        b5_reg  <= b_reg;
        bhh_reg <= $signed(b_reg[63:32]) * $signed(b_reg[63:32]);
        bhl_reg <= $signed(b_reg[63:32]) * $signed({1'b0, b_reg[31:0]});
        bll_reg <= b_reg[31:0] * b_reg[31:0];
        ahh_reg <= $signed(a_reg[63:32]) * $signed(c_reg[63:32]);
        ahl_reg <= $signed(a_reg[63:32]) * $signed({1'b0, c_reg[31:0]});
        alh_reg <= $signed({1'b0, a_reg[31:0]}) * $signed(c_reg[63:32]);
        all_reg <= a_reg[31:0] * c_reg[31:0];
    end

    // stage 6: full products
    always_comb
    begin
        bb_next = (128'(bhh_reg) <<< 64) + (128'(bhl_reg) <<< 33) + 128'(bll_reg);
        ac_next = (128'(ahh_reg) <<< 64) + (128'(ahl_reg) <<< 32)
                  + (128'(alh_reg) <<< 32) + 128'(all_reg);
    end

    always_ff @(posedge clk)
    begin
        p6_reg <= p5_reg;
        a6_reg <= a5_reg;
        b6_reg <= b5_reg;
        bb_reg <= bb_next;
        ac_reg <= ac_next;
    end

    // stage 7: discriminant and case flags, enter square root
    always_comb
    begin
        disc_w                = bb_reg - ac_reg;
        bsum_w                = 65'(b6_reg) + {49'd0, eps_reg};
        sq_next[0].prior      = p6_reg.prior;
        sq_next[0].best       = p6_reg.best;
        sq_next[0].a_ok       = !a6_reg[63] && (a6_reg != 64'd0)
                                && (a6_reg >= {48'd0, eps_reg});
        sq_next[0].small_disc = disc_w[127]
                                || (disc_w[127:16] == 112'd0 && disc_w[15:0] < eps_reg);
        sq_next[0].pri_ok     = bsum_w[64];
        sq_next[0].den        = a6_reg[62:0];
        sq_next[0].nb         = -65'(b6_reg);
        sq_next[0].x          = disc_w;
        sq_next[0].core.rem   = 67'd0;
        sq_next[0].core.root  = 64'd0;
    end

    always_ff @(posedge clk)
    begin
        sq_reg[0] <= sq_next[0];
    end

    for (genvar k = 0; k < rei_pkg::SQ_STEPS; k++) begin : g_sq
        always_comb
        begin
            sq_next[k+1]      = sq_reg[k];
            sq_next[k+1].core = rei_pkg::sqrt_step(sq_reg[k].core, sq_reg[k].x[127:126]);
            sq_next[k+1].x    = {sq_reg[k].x[125:0], 2'b00};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                sq_vld_reg[k+1] <= 1'b0;
            end else begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            sq_reg[k+1] <= sq_next[k+1];
        end
    end

    // root numerators
    always_comb
    begin
        num0_next = sq_reg[rei_pkg::SQ_STEPS].prior ? 67'(sq_reg[rei_pkg::SQ_STEPS].nb)
                    : 67'(sq_reg[rei_pkg::SQ_STEPS].nb)
                      - $signed({3'b000, sq_reg[rei_pkg::SQ_STEPS].core.root});
        num1_next = 67'(sq_reg[rei_pkg::SQ_STEPS].nb)
                    + $signed({3'b000, sq_reg[rei_pkg::SQ_STEPS].core.root});
        side_next.prior      = sq_reg[rei_pkg::SQ_STEPS].prior;
        side_next.best       = sq_reg[rei_pkg::SQ_STEPS].best;
        side_next.a_ok       = sq_reg[rei_pkg::SQ_STEPS].a_ok;
        side_next.small_disc = sq_reg[rei_pkg::SQ_STEPS].small_disc;
        side_next.pri_ok     = sq_reg[rei_pkg::SQ_STEPS].pri_ok;
    end

    always_ff @(posedge clk)
    begin
        num0_reg    <= num0_next;
        num1_reg    <= num1_next;
        den_reg     <= sq_reg[rei_pkg::SQ_STEPS].den;
        side_reg[0] <= side_next;
    end

    rei_div u_div0 (
        .clk (clk),
        .num (num0_reg),
        .den (den_reg),
        .lam (lam0_w)
    );

    rei_div u_div1 (
        .clk (clk),
        .num (num1_reg),
        .den (den_reg),
        .lam (lam1_w)
    );

    for (genvar k = 0; k < rei_pkg::DIV_LAT; k++) begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                side_vld_reg[k+1] <= 1'b0;
            end else begin
                side_vld_reg[k+1] <= side_vld_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            side_reg[k+1] <= side_reg[k];
        end
    end

    // pick the nearer valid root
    always_comb
    begin
        fin_w                    = side_reg[rei_pkg::DIV_LAT];
        eps_s                    = $signed({16'h0000, eps_reg});
        result_next.hit          = 1'b0;
        result_next.new_distance = fin_w.best;
        if (fin_w.a_ok) begin
            if (fin_w.prior) begin
                if (fin_w.pri_ok && lam0_w < fin_w.best) begin
                    result_next.hit          = 1'b1;
                    result_next.new_distance = lam0_w;
                end
            end else if (!fin_w.small_disc) begin
                if (eps_s < lam0_w && lam0_w < fin_w.best) begin
                    result_next.hit          = 1'b1;
                    result_next.new_distance = lam0_w;
                end else if (eps_s < lam1_w && lam1_w < fin_w.best) begin
                    result_next.hit          = 1'b1;
                    result_next.new_distance = lam1_w;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `REI_ASSERT_DELAY(a_latency, start, rei_pkg::LAT, done, "result strobe missing after item")
    `REI_ASSERT_IMP(a_hit_nearer, done && result.hit,
        $signed(result.new_distance) < $signed($past(side_reg[rei_pkg::DIV_LAT].best)),
        "hit distance not nearer than input best")
    `REI_ASSERT_IMP(a_miss_keeps, done && !result.hit,
        result.new_distance == $past(side_reg[rei_pkg::DIV_LAT].best),
        "miss altered distance")

endmodule

### bench/tb_ray_ellipsoid_intersect.sv
// Self-checking bench for ray_ellipsoid_intersect: directed and random rays over
// several matrix/epsilon settings, checked against an in-bench Q16.16 predictor.
// Depends on rei_pkg and the ray_ellipsoid_intersect RTL.
module tb_ray_ellipsoid_intersect;

    localparam int ONE       = 65536;
    localparam int MAX_CYC   = 300000;
    localparam int MAX_SHOWN = 10;

    localparam logic signed [127:0] S64_MAX = 128'sh7FFFFFFFFFFFFFFF;
    localparam logic signed [127:0] S64_MIN = -128'sh8000000000000000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    rei_pkg::ray_t ray = '0;
    logic         cfg_wen = 1'b0;
    logic [rei_pkg::REG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]  cfg_data = '0;
    logic         done;
    rei_pkg::res_t result;

    logic [63:0]  shadow_regs [7];
    rei_pkg::ray_t pending_rays [$];
    rei_pkg::res_t expected_hits [$];
    bit           steady = 1'b0;
    int           cycles = 0;
    int           mismatches = 0;
    int           rays_sent = 0;
    int           results_seen = 0;
    int           hits_seen = 0;

    ray_ellipsoid_intersect uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .ray       (ray),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [63:0] clamp64(input logic signed [127:0] v);
        if (v > S64_MAX)
        begin
            return S64_MAX[63:0];
        end
        if (v < S64_MIN)
        begin
            return S64_MIN[63:0];
        end
        return v[63:0];
    endfunction

    function automatic logic signed [31:0] mat_coef(input int r, input int k);
        logic [63:0] w;
        w = shadow_regs[r * 2 + (k >> 1)];
        return (k & 1) ? w[31:0] : w[63:32];
    endfunction

    function automatic logic signed [31:0] sext_coord(input logic signed [31:0] v);
        return (v <<< rei_pkg::CW_SHIFT) >>> rei_pkg::CW_SHIFT;
    endfunction

    function automatic logic signed [31:0] to_local(input int i, input logic signed [31:0] p0,
                                                    input logic signed [31:0] p1,
                                                    input logic signed [31:0] p2,
                                                    input bit with_t);
        logic signed [127:0] acc;
        logic signed [127:0] e;
        logic signed [127:0] x;
        logic signed [63:0]  s;
        logic signed [63:0]  sh;
        acc = 0;
        e = mat_coef(i, 0); x = p0; acc = acc + e * x;
        e = mat_coef(i, 1); x = p1; acc = acc + e * x;
        e = mat_coef(i, 2); x = p2; acc = acc + e * x;
        if (with_t)
        begin
            e = mat_coef(i, 3);
            acc = acc + (e <<< 16);
        end
        s = clamp64(acc);
        sh = s >>> 16;
        if (sh > 64'(rei_pkg::CW_MAX))
        begin
            sh = 64'(rei_pkg::CW_MAX);
        end
        else if (sh < 64'(rei_pkg::CW_MIN))
        begin
            sh = 64'(rei_pkg::CW_MIN);
        end
        return sh[31:0];
    endfunction

    function automatic logic signed [63:0] dot_q32(input logic signed [31:0] x [3],
                                                   input logic signed [31:0] y [3],
                                                   input logic signed [127:0] extra);
        logic signed [127:0] acc;
        logic signed [127:0] u;
        logic signed [127:0] v;
        acc = extra;
        for (int j = 0; j < 3; j++)
        begin
            u = x[j];
            v = y[j];
            acc = acc + u * v;
        end
        return clamp64(acc);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  cand;
        logic [127:0] sq;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            sq = {64'd0, cand} * {64'd0, cand};
            if (sq <= x)
            begin
                r = cand;
            end
        end
        return r;
    endfunction

    function automatic logic signed [63:0] scaled_quot(input logic [127:0] num,
                                                       input logic [63:0] den);
        logic         neg;
        logic [127:0] n;
        logic [127:0] qf;
        logic [63:0]  q;
        logic         big;
        neg = num[127];
        n = neg ? -num : num;
        n = n << 16;
        qf = n / {64'd0, den};
        big = |qf[127:64];
        q = qf[63:0];
        if (neg)
        begin
            return (big || q > 64'h80000000) ? -64'sd2147483648 : -$signed(q);
        end
        return (big || q > 64'h7FFFFFFF) ? 64'sd2147483647 : $signed(q);
    endfunction

    function automatic rei_pkg::res_t predict_hit(input rei_pkg::ray_t r);
        logic signed [31:0]  o [3];
        logic signed [31:0]  d [3];
        logic signed [31:0]  ow [3];
        logic signed [31:0]  dw [3];
        logic signed [63:0]  a;
        logic signed [63:0]  b;
        logic signed [63:0]  c;
        logic signed [63:0]  eps;
        logic signed [63:0]  lam;
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] wc;
        logic signed [127:0] nb;
        logic signed [127:0] disc;
        logic [127:0]        s;
        rei_pkg::res_t       res;
        res.hit = 1'b0;
        res.new_distance = r.best_distance;
        eps = {48'd0, shadow_regs[rei_pkg::REG_EPSILON][15:0]};
        ow[0] = sext_coord(r.origin_x); ow[1] = sext_coord(r.origin_y);
        ow[2] = sext_coord(r.origin_z);
        dw[0] = sext_coord(r.dir_x); dw[1] = sext_coord(r.dir_y); dw[2] = sext_coord(r.dir_z);
        for (int i = 0; i < 3; i++)
        begin
            o[i] = to_local(i, ow[0], ow[1], ow[2], 1'b1);
            d[i] = to_local(i, dw[0], dw[1], dw[2], 1'b0);
        end
        a = dot_q32(d, d, 0);
        b = dot_q32(d, o, 0);
        c = dot_q32(o, o, -(128'sd1 <<< 32));
        if (a > 0 && a >= eps)
        begin
            wa = a; wb = b; wc = c;
            nb = -wb;
            if (r.prior_hit)
            begin
                if (b < -eps)
                begin
                    lam = scaled_quot(nb, a);
                    if (lam < 64'(r.best_distance))
                    begin
                        res.hit = 1'b1;
                        res.new_distance = lam[31:0];
                    end
                end
            end
            else
            begin
                disc = wb * wb - wa * wc;
                if (!(disc[127] || (disc[127:64] == 0 && disc[63:0] < eps)))
                begin
                    s = {64'd0, floor_sqrt(disc)};
                    lam = scaled_quot(nb - s, a);
                    if (eps < lam && lam < 64'(r.best_distance))
                    begin
                        res.hit = 1'b1;
                        res.new_distance = lam[31:0];
                    end
                    else
                    begin
                        lam = scaled_quot(nb + s, a);
                        if (eps < lam && lam < 64'(r.best_distance))
                        begin
                            res.hit = 1'b1;
                            res.new_distance = lam[31:0];
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYC)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_hits.size());
            $display("ray_ellipsoid_intersect test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && (!start || !busy))
        begin
            if (start)
            begin
                expected_hits.push_back(predict_hit(ray));
                rays_sent++;
            end
            if (pending_rays.size() > 0 && (steady || $urandom_range(99) >= 30))
            begin
                ray <= pending_rays.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        rei_pkg::res_t exp_res;
        if (rst_n && done)
        begin
            results_seen++;
            if (result.hit)
            begin
                hits_seen++;
            end
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                begin
                    $display("unexpected result hit=%0b dist=%0d", result.hit,
                             result.new_distance);
                end
            end
            else
            begin
                exp_res = expected_hits.pop_front();
                if (result.hit !== exp_res.hit
                    || result.new_distance !== exp_res.new_distance)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("mismatch: expected hit=%0b dist=%0d, got hit=%0b dist=%0d",
                                 exp_res.hit, exp_res.new_distance, result.hit,
                                 result.new_distance);
                    end
                end
            end
        end
    end

    function automatic rei_pkg::ray_t mk_ray(input int ox, input int oy, input int oz,
                                             input int dx, input int dy, input int dz,
                                             input int best, input bit prior);
        rei_pkg::ray_t r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        r.best_distance = best;
        r.prior_hit = prior;
        return r;
    endfunction

    function automatic int near_coord(input int span);
        return $urandom_range(0, 2 * span * ONE) - span * ONE;
    endfunction

    function automatic rei_pkg::ray_t random_ray();
        rei_pkg::ray_t r;
        int            ox, oy, oz;
        if ($urandom_range(99) < 30)
        begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 1'($urandom)};
        end
        else
        begin
            ox = near_coord(5); oy = near_coord(5); oz = near_coord(5);
            r = mk_ray(ox, oy, oz, -ox + near_coord(1), -oy + near_coord(1),
                       -oz + near_coord(1), 0, $urandom_range(99) < 25);
            case ($urandom_range(3))
                0: r.best_distance = $urandom;
                1: r.best_distance = 32'sh7FFFFFFF;
                default: r.best_distance = $urandom_range(0, 4 * ONE);
            endcase
        end
        return r;
    endfunction

    task automatic write_reg(input rei_pkg::reg_idx_t idx, input logic [63:0] v);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        shadow_regs[idx] = (idx == rei_pkg::REG_EPSILON) ? {48'd0, v[15:0]} : v;
    endtask

    task automatic load_setting(input logic [63:0] v [7]);
        for (int i = 0; i < 7; i++)
        begin
            write_reg(rei_pkg::reg_idx_t'(i), v[i]);
        end
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_rays.size() == 0 && !start && expected_hits.size() == 0);
        repeat (rei_pkg::LAT + 10) @(posedge clk);
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_rays.push_back(random_ray());
    endtask

    initial
    begin
        logic [63:0] setting [7];
        shadow_regs[rei_pkg::REG_ROW0_LO] = rei_pkg::RST_ROW0_LO;
        shadow_regs[rei_pkg::REG_ROW0_HI] = rei_pkg::RST_ROW0_HI;
        shadow_regs[rei_pkg::REG_ROW1_LO] = rei_pkg::RST_ROW1_LO;
        shadow_regs[rei_pkg::REG_ROW1_HI] = rei_pkg::RST_ROW1_HI;
        shadow_regs[rei_pkg::REG_ROW2_LO] = rei_pkg::RST_ROW2_LO;
        shadow_regs[rei_pkg::REG_ROW2_HI] = rei_pkg::RST_ROW2_HI;
        shadow_regs[rei_pkg::REG_EPSILON] = {48'd0, rei_pkg::RST_EPSILON};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending_rays.push_back(mk_ray(-3 * ONE, 0, 0, ONE, 0, 0, 32'sh7FFFFFFF, 1'b0));
        pending_rays.push_back(mk_ray(0, 0, 0, ONE, 0, 0, 32'sh7FFFFFFF, 1'b0));
        pending_rays.push_back(mk_ray(0, 0, 0, 0, ONE, 0, 32'sh7FFFFFFF, 1'b1));
        pending_rays.push_back(mk_ray(-3 * ONE, 0, 0, ONE, 0, 0, 32'sh7FFFFFFF, 1'b1));
        pending_rays.push_back(mk_ray(-3 * ONE, 0, 0, -ONE, 0, 0, 32'sh7FFFFFFF, 1'b1));
        pending_rays.push_back(mk_ray(-3 * ONE, ONE, 0, ONE, 0, 0, 32'sh7FFFFFFF, 1'b0));
        pending_rays.push_back(mk_ray(-3 * ONE, 0, 0, 0, 0, 0, 32'sh7FFFFFFF, 1'b0));
        pending_rays.push_back(mk_ray(-3 * ONE, 0, 0, 1, 0, 0, 32'sh7FFFFFFF, 1'b0));
        pending_rays.push_back(mk_ray(-3 * ONE, 0, 0, ONE, 0, 0, ONE, 1'b0));
        pending_rays.push_back(mk_ray(-3 * ONE, 0, 0, ONE, 0, 0, 32'sh80000000, 1'b0));
        pending_rays.push_back(mk_ray(3 * ONE, 0, 0, ONE, 0, 0, 32'sh7FFFFFFF, 1'b0));
        pending_rays.push_back(mk_ray(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                      32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                      32'sh7FFFFFFF, 1'b1));
        pending_rays.push_back(mk_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      32'sh80000000, 1'b0));
        pending_rays.push_back(mk_ray(-1, -1, -1, -1, -1, -1, -1, 1'b1));
        pending_rays.push_back(mk_ray(0, 0, -2 * ONE, 0, 0, 1, 32'sh7FFFFFFF, 1'b0));
        queue_random(90);
        drain();

        setting = '{{32'sh8000, 32'sh0}, {32'sh0, 32'sh4000}, {32'sh0, 32'sh8000},
                    {32'sh0, -32'sh8000}, {32'sh0, 32'sh0}, {32'sh8000, 32'sh10000}, 64'd0};
        load_setting(setting);
        queue_random(100);
        drain();

        steady = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            setting[i] = {32'(near_coord(2)), 32'(near_coord(2))};
        end
        setting[rei_pkg::REG_EPSILON] = $urandom_range(0, 65535);
        load_setting(setting);
        queue_random(100);
        drain();
        steady = 1'b0;

        setting = '{default: '1};
        load_setting(setting);
        queue_random(40);
        drain();

        setting = '{{32'sh7FFFFFFF, 32'sh80000000}, {32'sh80000000, 32'sh7FFFFFFF},
                    {32'sh7FFFFFFF, 32'sh7FFFFFFF}, {32'sh80000000, 32'sh80000000},
                    {32'sh80000000, 32'sh7FFFFFFF}, {32'sh7FFFFFFF, 32'sh80000000},
                    64'd0};
        load_setting(setting);
        queue_random(30);
        drain();

        setting = '{rei_pkg::RST_ROW0_LO, rei_pkg::RST_ROW0_HI, rei_pkg::RST_ROW1_LO,
                    rei_pkg::RST_ROW1_HI, rei_pkg::RST_ROW2_LO, rei_pkg::RST_ROW2_HI,
                    64'd0};
        load_setting(setting);
        queue_random(60);
        drain();

        $display("covered %0d rays over six matrix/epsilon settings, %0d results, %0d hits",
                 rays_sent, results_seen, hits_seen);
        if (mismatches == 0)
        begin
            $display("ray_ellipsoid_intersect test passed");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("ray_ellipsoid_intersect test failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/rei_pkg.sv
sv/rei_div.sv
sv/ray_ellipsoid_intersect.sv
bench/tb_ray_ellipsoid_intersect.sv
